// ----- rtl/sce_pkg.sv -----
`default_nettype none

package sce_pkg;

  // Fixed formats of the stream fields.
  localparam int unsigned TargetFrac = 14;
  localparam int unsigned TabFrac    = 16;
  localparam int unsigned OutFrac    = 11;
  localparam int unsigned TabW       = 16;
  localparam int unsigned OutW       = 17;
  localparam int unsigned XuW        = 33;
  localparam int unsigned SumW       = 34;
  localparam int unsigned SegCount   = 17;
  localparam int          ValueMax   = 65535;
  localparam int          ValueMin   = -65536;

  // Mode register codes.
  localparam logic MODE_LOSS = 1'b0;
  localparam logic MODE_GRAD = 1'b1;

  // Per-beat control that rides along the pipeline.
  typedef struct packed {
    logic mode;
    logic keep;
    logic pos;
    logic last;
  } ctrl_t;

  // Table knots every 0.5 in units of 2^-16: softplus(-a) for loss,
  // 1/(1+exp(a)) for gradient. Codes past the last knot (17 and up) are zero.
  function automatic logic [TabW-1:0] knot(input logic sel, input logic [4:0] i);
    logic [TabW-1:0] r;
    r = '0;
    if (sel == MODE_LOSS) begin
      case (i)
        5'd0:    r = 16'd45426;
        5'd1:    r = 16'd31069;
        5'd2:    r = 16'd20530;
        5'd3:    r = 16'd13200;
        5'd4:    r = 16'd8318;
        5'd5:    r = 16'd5170;
        5'd6:    r = 16'd3184;
        5'd7:    r = 16'd1950;
        5'd8:    r = 16'd1189;
        5'd9:    r = 16'd724;
        5'd10:   r = 16'd440;
        5'd11:   r = 16'd267;
        5'd12:   r = 16'd162;
        5'd13:   r = 16'd98;
        5'd14:   r = 16'd60;
        5'd15:   r = 16'd36;
        5'd16:   r = 16'd22;
        default: r = '0;
      endcase
    end else begin
      case (i)
        5'd0:    r = 16'd32768;
        5'd1:    r = 16'd24742;
        5'd2:    r = 16'd17625;
        5'd3:    r = 16'd11955;
        5'd4:    r = 16'd7812;
        5'd5:    r = 16'd4971;
        5'd6:    r = 16'd3108;
        5'd7:    r = 16'd1921;
        5'd8:    r = 16'd1179;
        5'd9:    r = 16'd720;
        5'd10:   r = 16'd439;
        5'd11:   r = 16'd267;
        5'd12:   r = 16'd162;
        5'd13:   r = 16'd98;
        5'd14:   r = 16'd60;
        5'd15:   r = 16'd36;
        5'd16:   r = 16'd22;
        default: r = '0;
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sigmoid_cross_entropy_unit.sv -----
`default_nettype none

// Sigmoid binary cross entropy with logits, one element per beat.
// Input stream s_*: tdata carries the logit (signed Q4.11) and the target
// (Q1.14, negative means ignore); tlast marks the last element of a tensor.
// Output stream m_*: tdata carries the value (signed Q5.11, saturated);
// tuser is the mask bit (0 for an ignored element, whose value is zero);
// tlast is passed through from the same element.
// The mode register (cfg_we/cfg_wdata) selects loss (0) or gradient (1);
// write it only while the pipeline is empty.
// An input beat passes through table fetch, multiply, combine, and
// round/saturate, each a registered stage, to the output beat.
// Throughput is one beat per cycle while the receiver takes beats. Each
// stage takes a new beat whenever it is empty or its successor moves, so
// bubbles collapse and the input keeps accepting while a finished result
// waits in the output register. When the receiver stalls, the pipeline
// fills and then s_tready drops; nothing is lost or repeated.
// Synchronous reset empties all stages and returns the mode to loss.
module sigmoid_cross_entropy_unit #(
  parameter int unsigned LOGIT_FRAC_BITS = 11
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [15:0] logit, [31:16] target
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [16:0] value, [23:17] zero
  output logic             m_tuser,   // [0] valid_mask
  output logic             m_tlast
);

  localparam int unsigned FracW = LOGIT_FRAC_BITS - 1;
  localparam int unsigned IpW   = sce_pkg::TabW + LOGIT_FRAC_BITS - 1;

  logic mode;

  logic                      a_valid;
  logic                      a_ready;
  sce_pkg::ctrl_t            a_ctrl;
  logic [sce_pkg::TabW-1:0]  a_base;
  logic [sce_pkg::TabW-1:0]  a_slope;
  logic [FracW-1:0]          a_frac;
  logic signed [15:0]        a_x;
  logic signed [16:0]        a_u;
  logic [14:0]               a_tgt;

  logic                      b_valid;
  logic                      b_ready;
  sce_pkg::ctrl_t            b_ctrl;
  logic [sce_pkg::TabW-1:0]  b_base;
  logic [IpW-1:0]            b_ip;
  logic signed [sce_pkg::XuW-1:0] b_xu;
  logic [14:0]               b_tgt;

  logic signed [sce_pkg::OutW-1:0] value;

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= sce_pkg::MODE_LOSS;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  sce_lut #(.LOGIT_FRAC_BITS(LOGIT_FRAC_BITS)) u_lut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .logit     (s_tdata[15:0]),
    .target    (s_tdata[31:16]),
    .last      (s_tlast),
    .mode      (mode),
    .out_valid (a_valid),
    .out_ready (a_ready),
    .ctrl      (a_ctrl),
    .base      (a_base),
    .slope     (a_slope),
    .frac      (a_frac),
    .x         (a_x),
    .u         (a_u),
    .tgt       (a_tgt)
  );

  sce_mul #(.LOGIT_FRAC_BITS(LOGIT_FRAC_BITS)) u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_valid),
    .in_ready  (a_ready),
    .in_ctrl   (a_ctrl),
    .in_base   (a_base),
    .slope     (a_slope),
    .frac      (a_frac),
    .x         (a_x),
    .u         (a_u),
    .in_tgt    (a_tgt),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .ctrl      (b_ctrl),
    .base      (b_base),
    .ip        (b_ip),
    .xu        (b_xu),
    .tgt       (b_tgt)
  );

  sce_res #(.LOGIT_FRAC_BITS(LOGIT_FRAC_BITS)) u_res (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_valid),
    .in_ready  (b_ready),
    .in_ctrl   (b_ctrl),
    .base      (b_base),
    .ip        (b_ip),
    .xu        (b_xu),
    .tgt       (b_tgt),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .value     (value),
    .mask      (m_tuser),
    .last      (m_tlast)
  );

  assign m_tdata = {7'd0, value};

endmodule

`default_nettype wire

// ----- rtl/sce_lut.sv -----
`default_nettype none

// First stage: magnitude, segment index and table knots.
module sce_lut #(
  parameter int unsigned LOGIT_FRAC_BITS = 11
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [15:0]            logit,
  input  wire logic signed [15:0]            target,
  input  wire logic                          last,
  input  wire logic                          mode,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output sce_pkg::ctrl_t                     ctrl,
  output logic [sce_pkg::TabW-1:0]           base,
  output logic [sce_pkg::TabW-1:0]           slope,
  output logic [LOGIT_FRAC_BITS-2:0]         frac,
  output logic signed [15:0]                 x,
  output logic signed [16:0]                 u,
  output logic [14:0]                        tgt
);

  localparam int unsigned Sh = LOGIT_FRAC_BITS - 1;
  localparam logic signed [16:0] OneQ14 = 17'(1 << sce_pkg::TargetFrac);

  logic               valid;
  logic [16:0]        ext;
  logic [16:0]        mag;
  logic [16:0]        seg;
  logic               far;
  logic [4:0]         i0;
  logic [4:0]         i1;
  logic [sce_pkg::TabW-1:0] k0;
  logic [sce_pkg::TabW-1:0] k1;
  logic signed [16:0] t_ext;
  logic signed [16:0] u_next;
  sce_pkg::ctrl_t     ctrl_next;

  // Magnitude of the logit and the table segment it falls in.
  always_comb begin
    ext   = {logit[15], logit};
    mag   = logit[15] ? (17'd0 - ext) : ext;
    seg   = mag >> Sh;
    far   = seg >= 17'(sce_pkg::SegCount);
    i0    = seg[4:0];
    i1    = i0 + 5'd1;
    k0    = far ? '0 : sce_pkg::knot(mode, i0);
    k1    = far ? '0 : sce_pkg::knot(mode, i1);
    t_ext = {target[15], target};
    u_next = logit[15] ? (17'sd0 - t_ext) : (OneQ14 - t_ext);
    ctrl_next.mode = mode;
    ctrl_next.keep = ~target[15];
    ctrl_next.pos  = ~logit[15];
    ctrl_next.last = last;
  end

  assign in_ready  = ~valid | out_ready;
  assign out_valid = valid;

  // Stage valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (in_ready) begin
      ctrl  <= ctrl_next;
      base  <= k0;
      slope <= k0 - k1;
      frac  <= mag[Sh-1:0];
      x     <= logit;
      u     <= u_next;
      tgt   <= target[14:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sce_mul.sv -----
`default_nettype none

// Second stage: interpolation product and the logit-times-target term.
module sce_mul #(
  parameter int unsigned LOGIT_FRAC_BITS = 11
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire sce_pkg::ctrl_t                          in_ctrl,
  input  wire logic [sce_pkg::TabW-1:0]                in_base,
  input  wire logic [sce_pkg::TabW-1:0]                slope,
  input  wire logic [LOGIT_FRAC_BITS-2:0]              frac,
  input  wire logic signed [15:0]                      x,
  input  wire logic signed [16:0]                      u,
  input  wire logic [14:0]                             in_tgt,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output sce_pkg::ctrl_t                               ctrl,
  output logic [sce_pkg::TabW-1:0]                     base,
  output logic [sce_pkg::TabW+LOGIT_FRAC_BITS-2:0]     ip,
  output logic signed [sce_pkg::XuW-1:0]               xu,
  output logic [14:0]                                  tgt
);

  logic valid;

  assign in_ready  = ~valid | out_ready;
  assign out_valid = valid;

  // Stage valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Two independent multipliers, each registered.
  always_ff @(posedge clk) begin
    if (in_ready) begin
      ctrl <= in_ctrl;
      base <= in_base;
      ip   <= slope * frac;
      xu   <= x * u;
      tgt  <= in_tgt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sce_res.sv -----
`default_nettype none

// Third and fourth stages: combine into one fixed-point sum, then round,
// saturate and apply the ignore mask into the output register.
module sce_res #(
  parameter int unsigned LOGIT_FRAC_BITS = 11
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire sce_pkg::ctrl_t                          in_ctrl,
  input  wire logic [sce_pkg::TabW-1:0]                base,
  input  wire logic [sce_pkg::TabW+LOGIT_FRAC_BITS-2:0] ip,
  input  wire logic signed [sce_pkg::XuW-1:0]          xu,
  input  wire logic [14:0]                             tgt,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic signed [sce_pkg::OutW-1:0]              value,
  output logic                                         mask,
  output logic                                         last
);

  localparam int unsigned Sh     = LOGIT_FRAC_BITS - 1;
  localparam int unsigned SumW   = sce_pkg::SumW;
  localparam int unsigned SpSh   = LOGIT_FRAC_BITS + sce_pkg::TargetFrac - sce_pkg::TabFrac;
  localparam int unsigned LossSh = LOGIT_FRAC_BITS + sce_pkg::TargetFrac - sce_pkg::OutFrac;
  localparam int unsigned GradSh = sce_pkg::TabFrac - sce_pkg::OutFrac;
  localparam int unsigned TgtSh  = sce_pkg::TabFrac - sce_pkg::TargetFrac;
  localparam logic [SumW-1:0] HalfLoss = SumW'(1) << (LossSh - 1);
  localparam logic [SumW-1:0] HalfGrad = SumW'(1) << (GradSh - 1);
  localparam logic [16:0] OneQ16 = 17'(1 << sce_pkg::TabFrac);
  localparam logic signed [SumW-1:0] VMax = SumW'(sce_pkg::ValueMax);
  localparam logic signed [SumW-1:0] VMin = SumW'(sce_pkg::ValueMin);

  logic                   v3;
  logic                   v4;
  logic                   ready4;
  sce_pkg::ctrl_t         c3;
  logic signed [SumW-1:0] sum;

  logic [sce_pkg::TabW-1:0] f;
  logic signed [SumW-1:0] sp_ext;
  logic signed [SumW-1:0] xu_ext;
  logic [16:0]            sig;
  logic [16:0]            tq;
  logic signed [SumW-1:0] sum_next;

  logic signed [SumW-1:0] biased;
  logic signed [SumW-1:0] r;
  logic signed [sce_pkg::OutW-1:0] sat;

  // Interpolated table value and the mode's pre-rounding sum.
  always_comb begin
    f      = base - ip[Sh +: sce_pkg::TabW];
    sp_ext = SumW'(f) << SpSh;
    xu_ext = SumW'(xu);
    sig    = in_ctrl.pos ? (OneQ16 - {1'b0, f}) : {1'b0, f};
    tq     = 17'(tgt) << TgtSh;
    if (in_ctrl.mode == sce_pkg::MODE_GRAD) begin
      sum_next = SumW'(sig) - SumW'(tq);
    end else begin
      sum_next = sp_ext + xu_ext;
    end
  end

  // Round half up, then clamp to the output range.
  always_comb begin
    if (c3.mode == sce_pkg::MODE_GRAD) begin
      biased = sum + HalfGrad;
      r      = biased >>> GradSh;
    end else begin
      biased = sum + HalfLoss;
      r      = biased >>> LossSh;
    end
    if (r > VMax) begin
      sat = VMax[sce_pkg::OutW-1:0];
    end else if (r < VMin) begin
      sat = VMin[sce_pkg::OutW-1:0];
    end else begin
      sat = r[sce_pkg::OutW-1:0];
    end
  end

  assign ready4    = ~v4 | out_ready;
  assign in_ready  = ~v3 | ready4;
  assign out_valid = v4;

  // Valid bits of both stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (in_ready) begin
        v3 <= in_valid;
      end
      if (ready4) begin
        v4 <= v3;
      end
    end
  end

  // Sum register.
  always_ff @(posedge clk) begin
    if (in_ready) begin
      c3  <= in_ctrl;
      sum <= sum_next;
    end
  end

  // Output register; an ignored element gives zero with the mask low.
  always_ff @(posedge clk) begin
    if (ready4) begin
      value <= c3.keep ? sat : '0;
      mask  <= c3.keep;
      last  <= c3.last;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sce_chk.sv -----
`default_nettype none

// Port-level checks on the output stream.
module sce_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata,
  input wire logic        m_tuser,
  input wire logic        m_tlast
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A stalled beat holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled output beat changed");

  // An ignored element carries a zero value.
  a_masked_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 24'd0)
    else $error("ignored element has nonzero value");

  // Padding bits above the value stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[23:17] == 7'd0)
    else $error("output padding not zero");

endmodule

bind sigmoid_cross_entropy_unit sce_chk u_sce_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// ----- sim/tb_sigmoid_cross_entropy_unit.sv -----
`timescale 1ns / 100ps

module tb_sigmoid_cross_entropy_unit;

  localparam int LogitFrac = 11;
  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles = 8;
  localparam int LongHoldCycles = 150;
  localparam int PhaseItems = 70;

  // Knots every 0.5 of |x| in units of 2^-16.
  localparam int SOFTPLUS_KNOTS [18] = '{
    45426, 31069, 20530, 13200, 8318, 5170, 3184, 1950, 1189,
    724, 440, 267, 162, 98, 60, 36, 22, 0
  };
  localparam int LOGISTIC_KNOTS [18] = '{
    32768, 24742, 17625, 11955, 7812, 4971, 3108, 1921, 1179,
    720, 439, 267, 162, 98, 60, 36, 22, 0
  };

  typedef struct {
    logic [15:0] logit;
    logic [15:0] target;
    logic        last;
  } bce_item_t;

  typedef struct {
    logic [16:0] value;
    logic        mask;
    logic        last;
  } bce_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = sce_pkg::MODE_LOSS;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  bce_item_t   pending_items [$];
  bce_result_t expected_results [$];
  bce_item_t   next_item;
  logic        mode_shadow = sce_pkg::MODE_LOSS;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_taken = 1'b0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  int          errors = 0;
  int          n_queued = 0;
  int          n_checked = 0;
  int          n_loss = 0;
  int          n_grad = 0;
  int          n_ignored = 0;
  int          n_above_one = 0;

  sigmoid_cross_entropy_unit #(
    .LOGIT_FRAC_BITS(LogitFrac)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  // Piecewise linear table value at magnitude mag (Q.11), result in Q.16.
  function automatic longint knot_interp(input logic use_logistic, input int mag);
    int     seg;
    int     frac;
    longint hi;
    longint lo;
    seg = mag >> (LogitFrac - 1);
    frac = mag & ((1 << (LogitFrac - 1)) - 1);
    if (seg >= int'(sce_pkg::SegCount)) return 0;
    hi = use_logistic ? LOGISTIC_KNOTS[seg] : SOFTPLUS_KNOTS[seg];
    lo = use_logistic ? LOGISTIC_KNOTS[seg + 1] : SOFTPLUS_KNOTS[seg + 1];
    return hi - (((hi - lo) * frac) >>> (LogitFrac - 1));
  endfunction

  // Round half up to Q5.11 by a right shift, then clamp to the output range.
  function automatic logic [16:0] round_to_q511(input longint v, input int sh);
    longint r;
    r = (v + (longint'(1) <<< (sh - 1))) >>> sh;
    if (r > sce_pkg::ValueMax) r = sce_pkg::ValueMax;
    if (r < sce_pkg::ValueMin) r = sce_pkg::ValueMin;
    return r[16:0];
  endfunction

  // Expected output beat for one element under the given mode.
  function automatic bce_result_t predict_bce(input logic [15:0] logit,
                                              input logic [15:0] target,
                                              input logic last, input logic mode);
    bce_result_t res;
    int          x;
    int          t;
    int          mag;
    longint      acc;
    longint      sig;
    x = $signed(logit);
    t = $signed(target);
    mag = (x < 0) ? -x : x;
    res.value = '0;
    res.mask = 1'b0;
    res.last = last;
    if (t >= 0) begin
      res.mask = 1'b1;
      if (mode == sce_pkg::MODE_LOSS) begin
        acc = knot_interp(1'b0, mag) <<< (LogitFrac + int'(sce_pkg::TargetFrac)
                                          - int'(sce_pkg::TabFrac));
        acc = acc + longint'(x) * ((x >= 0 ? (1 << sce_pkg::TargetFrac) : 0) - t);
        res.value = round_to_q511(acc, LogitFrac + int'(sce_pkg::TargetFrac)
                                       - int'(sce_pkg::OutFrac));
      end else begin
        sig = knot_interp(1'b1, mag);
        if (x >= 0) sig = (longint'(1) <<< sce_pkg::TabFrac) - sig;
        acc = sig - (longint'(t) <<< (int'(sce_pkg::TabFrac) - int'(sce_pkg::TargetFrac)));
        res.value = round_to_q511(acc, int'(sce_pkg::TabFrac) - int'(sce_pkg::OutFrac));
      end
    end
    return res;
  endfunction

  // Input side: record accepted beats and present the next pending element.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(predict_bce(s_tdata[15:0], s_tdata[31:16], s_tlast,
                                               mode_shadow));
        if (mode_shadow == sce_pkg::MODE_LOSS) n_loss++;
        else n_grad++;
        if ($signed(s_tdata[31:16]) > (1 << sce_pkg::TargetFrac)) n_above_one++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_item = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {next_item.target, next_item.logit};
          s_tlast <= next_item.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: random backpressure, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= LongHoldCycles;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Compare each output beat with the oldest expectation.
  always @(posedge clk) begin
    bce_result_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat value %0d mask %0b last %0b", $time,
                 $signed(m_tdata[16:0]), m_tuser, m_tlast);
      end else begin
        exp_res = expected_results.pop_front();
        n_checked++;
        if (!exp_res.mask) n_ignored++;
        if (m_tdata !== {7'b0, exp_res.value} || m_tuser !== exp_res.mask ||
            m_tlast !== exp_res.last) begin
          errors++;
          $display("%0t: mismatch expected value %0d mask %0b last %0b, got tdata %h mask %b last %b",
                   $time, $signed(exp_res.value), exp_res.mask, exp_res.last,
                   m_tdata, m_tuser, m_tlast);
        end
      end
    end
  end

  // Give up if no beat moves on either side for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("sigmoid_cross_entropy_unit verification failed");
        $finish;
      end
    end
  end

  function automatic logic [15:0] rand_logit();
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 65535);
      1: v = $urandom_range(0, 34816) - 17408;
      2: v = $urandom_range(0, 4096) - 2048;
      default: v = $urandom_range(0, 1) ? $urandom_range(16896, 17920)
                                        : -$urandom_range(16896, 17920);
    endcase
    return v[15:0];
  endfunction

  function automatic logic [15:0] rand_target();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 60) v = $urandom_range(0, 1 << sce_pkg::TargetFrac);
    else if (r < 70) v = $urandom_range(0, 1) ? (1 << sce_pkg::TargetFrac) : 0;
    else if (r < 80) v = $urandom_range((1 << sce_pkg::TargetFrac) + 1, 32767);
    else v = 32'h8000 | $urandom_range(0, 32767);
    return v[15:0];
  endfunction

  // Hold off new input until every queued element has come back out.
  task automatic wait_drained();
    while (n_checked != n_queued)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    mode_shadow = mode;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Range ends, the far-logit boundary, ignored and above-one targets.
  task automatic run_directed(input logic mode);
    logic [15:0] d_logit [12];
    logic [15:0] d_target [12];
    bce_item_t   it;
    d_logit  = '{16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h4400, 16'h43FF,
                 16'hBC00, 16'hBC01, 16'h0001, 16'hFFFF, 16'h0400, 16'hF800};
    d_target = '{16'h0000, 16'h4000, 16'h0000, 16'h7FFF, 16'h2000, 16'h2000,
                 16'h0000, 16'h4000, 16'hFFFF, 16'h8000, 16'h4000, 16'h7FFF};
    write_mode(mode);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 12; i++) begin
      it.logit = d_logit[i];
      it.target = d_target[i];
      it.last = i[0];
      pending_items.push_back(it);
      n_queued++;
    end
  endtask

  task automatic run_random(input logic mode, input int send_pct, input int recv_pct,
                            input logic long_hold);
    bce_item_t it;
    write_mode(mode);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    if (long_hold) hold_req <= 1'b1;
    for (int i = 0; i < PhaseItems; i++) begin
      it.logit = rand_logit();
      it.target = rand_target();
      it.last = ($urandom_range(0, 7) == 0);
      pending_items.push_back(it);
      n_queued++;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed(sce_pkg::MODE_LOSS);
    run_directed(sce_pkg::MODE_GRAD);

    run_random(sce_pkg::MODE_LOSS, 0, 0, 1'b0);
    run_random(sce_pkg::MODE_GRAD, 0, 0, 1'b1);
    run_random(sce_pkg::MODE_LOSS, 57, 0, 1'b0);
    run_random(sce_pkg::MODE_GRAD, 57, 0, 1'b0);
    run_random(sce_pkg::MODE_LOSS, 0, 57, 1'b0);
    run_random(sce_pkg::MODE_GRAD, 0, 57, 1'b0);
    run_random(sce_pkg::MODE_LOSS, 11, 11, 1'b0);
    run_random(sce_pkg::MODE_GRAD, 11, 11, 1'b0);

    wait_drained();
    if (expected_results.size() != 0) begin
      errors += expected_results.size();
      $display("%0t: %0d expected beats never arrived", $time, expected_results.size());
    end

    $display("Checked %0d output beats: %0d in loss mode, %0d in gradient mode.",
             n_checked, n_loss, n_grad);
    $display("Of these %0d had ignored targets and %0d targets above one.",
             n_ignored, n_above_one);
    if (errors == 0) begin
      $display("sigmoid_cross_entropy_unit verification clean");
    end else begin
      $display("sigmoid_cross_entropy_unit verification failed");
    end
    $finish;
  end

endmodule
